>>> hdl/vdd_pkg.sv
// Shared types, constants and the width helper function of the varint delta decoder.
`timescale 1ns / 1ps

package vdd_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int IN_DATA_W     = 8;
    localparam int IN_USER_W     = 7;
    localparam int VALUE_W       = 64;
    localparam int NARROW_W      = 32;
    localparam int COUNT_W       = 4;
    localparam int BITPOS_W      = 7;
    localparam int SLOT_FIELD_W  = 3;
    localparam int OUT_DATA_W    = 72;
    localparam int CONT_BIT      = 7;

    localparam logic                CMD_DATA  = 1'b0;
    localparam logic                CMD_CLEAR = 1'b1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = 4'd15;

    typedef struct packed {
        logic                    cmd;
        logic [IN_DATA_W-1:0]    data_byte;
        logic                    signed_mode;
        logic                    wide_mode;
        logic [SLOT_FIELD_W-1:0] delta_slot;
        logic                    accumulate;
    } vdd_item_t;

    // Cuts a value to the selected result width, sign- or zero-extending in 32-bit mode.
    function automatic logic [VALUE_W-1:0] fit_width(
        input logic [VALUE_W-1:0] v,
        input logic               wide,
        input logic               sgn
    );
        logic [VALUE_W-1:0] r;
        if (wide)
        begin
            r = v;
        end
        else
        begin
            r = {{(VALUE_W-NARROW_W){sgn & v[NARROW_W-1]}}, v[NARROW_W-1:0]};
        end
        return r;
    endfunction

endpackage

>>> hdl/vdd_in_stage.sv
// Input register of the decoder, with reduction of the slot select to the slot count.
`timescale 1ns / 1ps

module vdd_in_stage #(
    parameter int NUM_SLOTS = vdd_pkg::NUM_SLOTS_DEF,
    parameter int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  vdd_pkg::vdd_item_t s_item,
    input  logic               go,
    output logic               item_valid,
    output vdd_pkg::vdd_item_t item,
    output logic [SLOT_W-1:0]  slot_idx
);

    localparam int MOD_W = $clog2(NUM_SLOTS + 8) + 1;

    logic               in_valid_reg;
    logic               in_valid_next;
    vdd_pkg::vdd_item_t item_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [MOD_W-1:0]   slot_mod;
    logic               load;

    assign s_tready = !in_valid_reg || go;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        slot_mod = MOD_W'(s_item.delta_slot);
        for (int k = 0; k < 8; k++)
        begin
            if (slot_mod >= MOD_W'(NUM_SLOTS))
            begin
                slot_mod = slot_mod - MOD_W'(NUM_SLOTS);
            end
        end
    end

    always_comb
    begin
        if (load)
        begin
            in_valid_next = 1'b1;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= s_item;
            slot_reg <= slot_mod[SLOT_W-1:0];
        end
    end

    assign item_valid = in_valid_reg;
    assign item       = item_reg;
    assign slot_idx   = slot_reg;

endmodule

>>> hdl/vdd_core.sv
// Varint decode state, delta accumulators and result register.
`timescale 1ns / 1ps

module vdd_core #(
    parameter int NUM_SLOTS = vdd_pkg::NUM_SLOTS_DEF,
    parameter int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  vdd_pkg::vdd_item_t            item,
    input  logic [SLOT_W-1:0]             slot_idx,
    output logic                          go,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vdd_pkg::VALUE_W-1:0]   value,
    output logic [vdd_pkg::COUNT_W-1:0]   byte_count
);

    localparam logic [vdd_pkg::BITPOS_W-1:0] POS_NARROW = vdd_pkg::BITPOS_W'(vdd_pkg::NARROW_W);
    localparam logic [vdd_pkg::BITPOS_W-1:0] POS_WIDE   = vdd_pkg::BITPOS_W'(vdd_pkg::VALUE_W);
    localparam logic [vdd_pkg::BITPOS_W-1:0] POS_STEP   = 7'd7;

    logic [vdd_pkg::VALUE_W-1:0]  partial_reg;
    logic [vdd_pkg::BITPOS_W-1:0] pos_reg;
    logic                         busy_reg;
    logic                         sign_reg;
    logic                         sgn_reg;
    logic                         wide_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic                         accum_reg;
    logic [vdd_pkg::COUNT_W-1:0]  count_reg;
    logic [vdd_pkg::VALUE_W-1:0]  sums_reg [NUM_SLOTS];
    logic                         out_valid_reg;
    logic [vdd_pkg::VALUE_W-1:0]  out_value_reg;
    logic [vdd_pkg::COUNT_W-1:0]  out_count_reg;

    logic [vdd_pkg::VALUE_W-1:0]  partial_next;
    logic [vdd_pkg::BITPOS_W-1:0] pos_next;
    logic                         sign_next;
    logic                         sgn_next;
    logic                         wide_next;
    logic [SLOT_W-1:0]            slot_next;
    logic                         accum_next;
    logic [vdd_pkg::COUNT_W-1:0]  count_next;
    logic [vdd_pkg::BITPOS_W-1:0] pos_limit;
    logic [vdd_pkg::VALUE_W-1:0]  payload;
    logic [vdd_pkg::VALUE_W-1:0]  raw_value;
    logic [vdd_pkg::VALUE_W-1:0]  fitted;
    logic [vdd_pkg::VALUE_W-1:0]  sum_next;
    logic [vdd_pkg::VALUE_W-1:0]  result;
    logic                         is_clear;
    logic                         is_last;
    logic                         emits;

    assign is_clear = (item.cmd == vdd_pkg::CMD_CLEAR);
    assign is_last  = !item.data_byte[vdd_pkg::CONT_BIT];
    assign emits    = !is_clear && is_last;
    assign go       = item_valid && (!emits || !out_valid_reg || m_tready);
    assign payload  = {57'b0, item.data_byte[6:0]};

    always_comb
    begin
        if (!busy_reg)
        begin
            sgn_next   = item.signed_mode;
            wide_next  = item.wide_mode;
            slot_next  = slot_idx;
            accum_next = item.accumulate;
            count_next = 4'd1;
            pos_limit  = POS_WIDE;
            if (item.signed_mode)
            begin
                sign_next    = item.data_byte[0];
                partial_next = {58'b0, item.data_byte[6:1]};
                pos_next     = 7'd6;
            end
            else
            begin
                sign_next    = 1'b0;
                partial_next = payload;
                pos_next     = 7'd7;
            end
        end
        else
        begin
            sgn_next   = sgn_reg;
            wide_next  = wide_reg;
            slot_next  = slot_reg;
            accum_next = accum_reg;
            sign_next  = sign_reg;
            pos_limit  = wide_reg ? POS_WIDE : POS_NARROW;
            // Earlier groups sit strictly below pos_reg, so the new group can be ORed in.
            if (pos_reg < pos_limit)
            begin
                partial_next = partial_reg | (payload << pos_reg);
            end
            else
            begin
                partial_next = partial_reg;
            end
            if (pos_reg < POS_WIDE)
            begin
                pos_next = pos_reg + POS_STEP;
            end
            else
            begin
                pos_next = pos_reg;
            end
            if (count_reg < vdd_pkg::COUNT_MAX)
            begin
                count_next = count_reg + 4'd1;
            end
            else
            begin
                count_next = count_reg;
            end
        end

        raw_value = (sgn_next && sign_next) ? ~partial_next : partial_next;
        fitted    = vdd_pkg::fit_width(raw_value, wide_next, sgn_next);
        sum_next  = vdd_pkg::fit_width(sums_reg[slot_next] + fitted, wide_next, sgn_next);
        result    = accum_next ? sum_next : fitted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pos_reg     <= '0;
            busy_reg    <= 1'b0;
            sign_reg    <= 1'b0;
            sgn_reg     <= 1'b0;
            wide_reg    <= 1'b0;
            slot_reg    <= '0;
            accum_reg   <= 1'b0;
            count_reg   <= '0;
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                sums_reg[k] <= '0;
            end
        end
        else if (go)
        begin
            if (is_clear)
            begin
                partial_reg <= '0;
                pos_reg     <= '0;
                busy_reg    <= 1'b0;
                sign_reg    <= 1'b0;
                sgn_reg     <= 1'b0;
                wide_reg    <= 1'b0;
                slot_reg    <= '0;
                accum_reg   <= 1'b0;
                count_reg   <= '0;
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    sums_reg[k] <= '0;
                end
            end
            else
            begin
                sgn_reg   <= sgn_next;
                wide_reg  <= wide_next;
                slot_reg  <= slot_next;
                accum_reg <= accum_next;
                if (is_last)
                begin
                    partial_reg <= '0;
                    pos_reg     <= '0;
                    busy_reg    <= 1'b0;
                    sign_reg    <= 1'b0;
                    count_reg   <= '0;
                    if (accum_next)
                    begin
                        sums_reg[slot_next] <= sum_next;
                    end
                end
                else
                begin
                    partial_reg <= partial_next;
                    pos_reg     <= pos_next;
                    busy_reg    <= 1'b1;
                    sign_reg    <= sign_next;
                    count_reg   <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && emits)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emits)
        begin
            out_value_reg <= result;
            out_count_reg <= count_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign value      = out_value_reg;
    assign byte_count = out_count_reg;

endmodule

>>> hdl/varint_delta_decoder.sv
// Top level of the streaming varint decoder with zigzag sign and delta accumulators.
// The block takes one input word per clock while s_tready is high, and returns one result word
// for every data byte whose continuation bit (bit 7) is clear; a clear command on tuser bit 0
// resets all accumulators and any partial varint without producing a result. Each word passes
// an input register and a result register, and with m_tready held high the sustained rate is
// one byte per cycle. A final byte waits in the input register only while an earlier result
// is held by a low m_tready. The mode bits are sampled at the first byte of each varint, and
// the slot select is taken modulo NUM_SLOTS.
`timescale 1ns / 1ps

module varint_delta_decoder #(
    parameter int NUM_SLOTS = vdd_pkg::NUM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // From bit 0: data_byte.
    input  logic [vdd_pkg::IN_DATA_W-1:0]   s_tdata,
    // From bit 0: cmd, signed_mode, wide_mode, delta_slot (3 bits), accumulate.
    input  logic [vdd_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0: value (64 bits), byte_count (4 bits), zero padding (4 bits).
    output logic [vdd_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    vdd_pkg::vdd_item_t           s_item;
    vdd_pkg::vdd_item_t           item;
    logic                         item_valid;
    logic                         go;
    logic [SLOT_W-1:0]            slot_idx;
    logic [vdd_pkg::VALUE_W-1:0]  value;
    logic [vdd_pkg::COUNT_W-1:0]  byte_count;

    always_comb
    begin
        s_item.cmd         = s_tuser[0];
        s_item.data_byte   = s_tdata;
        s_item.signed_mode = s_tuser[1];
        s_item.wide_mode   = s_tuser[2];
        s_item.delta_slot  = s_tuser[5:3];
        s_item.accumulate  = s_tuser[6];
    end

    vdd_in_stage #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .go         (go),
        .item_valid (item_valid),
        .item       (item),
        .slot_idx   (slot_idx)
    );

    vdd_core #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .slot_idx   (slot_idx),
        .go         (go),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .value      (value),
        .byte_count (byte_count)
    );

    assign m_tdata = {4'b0, byte_count, value};

endmodule

>>> hdl/vdd_checker.sv
// Port-level checks of the varint delta decoder and their binding to the top level.
`timescale 1ns / 1ps

module vdd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [vdd_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // A held result word must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result word changed while stalled.");

    // Every varint holds at least one byte.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[67:64] != 4'd0)
        else $error("Result word carries a zero byte count.");

    // The padding bits above the byte count stay clear.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[71:68] == 4'd0)
        else $error("Result padding bits are not zero.");

    // With the result register empty, the input side can always take a word.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("Input stalled although no result is pending.");

endmodule

bind varint_delta_decoder vdd_checker u_vdd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
